@@ rtl/pip_pkg.sv @@
`timescale 1ns / 1ps
// Package for the point-in-polygon test block: defaults, item modes, FSM states
// and the status struct of the edge unit. No dependencies.

package pip_pkg;

  localparam int unsigned MaxVerticesDef = 64;
  localparam int unsigned CoordBitsDef   = 16;
  localparam int unsigned CrossBits      = 7;

  typedef enum logic [1:0] {
    ModeClear  = 2'd0,
    ModeAppend = 2'd1,
    ModeQuery  = 2'd2
  } pip_mode_e;

  typedef enum logic [2:0] {
    StIdle,
    StWalk,
    StWrap,
    StTail,
    StDrain
  } pip_state_e;

  typedef struct packed {
    logic busy;
    logic on_bnd;
  } pip_stat_t;

endpackage

@@ rtl/pip_item_if.sv @@
`timescale 1ns / 1ps
// Valid/ready channel interfaces for input items and query results.
// Depends on pip_pkg.

interface pip_item_if #(
  parameter int unsigned CoordBits = pip_pkg::CoordBitsDef
);
  logic                        valid;
  logic                        ready;
  logic [1:0]                  mode;
  logic signed [CoordBits-1:0] point_x;
  logic signed [CoordBits-1:0] point_y;

  modport source (output valid, mode, point_x, point_y, input ready);
  modport sink   (input valid, mode, point_x, point_y, output ready);
endinterface

interface pip_res_if;
  import pip_pkg::*;
  logic                 valid;
  logic                 ready;
  logic                 inside_res;
  logic                 on_boundary;
  logic [CrossBits-1:0] crossings;
  logic                 overflowed;

  modport source (output valid, inside_res, on_boundary, crossings, overflowed, input ready);
  modport sink   (input valid, inside_res, on_boundary, crossings, overflowed, output ready);
endinterface

@@ rtl/pip_ram.sv @@
`timescale 1ns / 1ps
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.

module pip_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/pip_edge_unit.sv @@
`timescale 1ns / 1ps
// Three-stage edge test unit: differences, cross products, then sign test and
// accumulation of crossings and boundary hits. Depends on pip_pkg.

module pip_edge_unit #(
  parameter int unsigned MaxVertices = pip_pkg::MaxVerticesDef,
  parameter int unsigned CoordBits   = pip_pkg::CoordBitsDef
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    clr_i,
  input  logic                                    feed_i,
  input  logic signed [CoordBits-1:0]             x1_i,
  input  logic signed [CoordBits-1:0]             y1_i,
  input  logic signed [CoordBits-1:0]             x2_i,
  input  logic signed [CoordBits-1:0]             y2_i,
  input  logic signed [CoordBits-1:0]             px_i,
  input  logic signed [CoordBits-1:0]             py_i,
  output pip_pkg::pip_stat_t                      stat_o,
  output logic [$clog2(MaxVertices+1)-1:0]        cnt_o
);
  import pip_pkg::*;

  localparam int unsigned DW   = CoordBits + 1;
  localparam int unsigned PW   = 2 * DW;
  localparam int unsigned CntW = $clog2(MaxVertices + 1);

  logic                 s1_v_q, s2_v_q;
  logic signed [DW-1:0] dx_d, dy_d, ex_d, ey_d;
  logic signed [DW-1:0] dx_q, dy_q, ex_q, ey_q;
  logic                 eqv_d, boxx_d, spany_d;
  logic                 eqv_q, boxx_q, spany_q, dynz_q, dyneg_q;
  logic                 eqv2_q, boxx2_q, spany2_q, dynz2_q, dyneg2_q;
  logic signed [PW-1:0] p1_q, p2_q;
  logic signed [PW:0]   c_diff;
  logic                 c_zero, c_neg, hit_onb, hit_cnt;
  logic [CntW-1:0]      cnt_q, cnt_d;
  logic                 onb_q, onb_d;

  always_comb begin
    dx_d    = DW'(x2_i) - DW'(x1_i);
    dy_d    = DW'(y2_i) - DW'(y1_i);
    ex_d    = DW'(px_i) - DW'(x1_i);
    ey_d    = DW'(py_i) - DW'(y1_i);
    eqv_d   = (x1_i == px_i) && (y1_i == py_i);
    boxx_d  = ((px_i >= x1_i) && (px_i <= x2_i)) || ((px_i >= x2_i) && (px_i <= x1_i));
    spany_d = ((py_i >= y1_i) && (py_i <= y2_i)) || ((py_i >= y2_i) && (py_i <= y1_i));
  end

  always_ff @(posedge clk_i) begin
    dx_q     <= dx_d;
    dy_q     <= dy_d;
    ex_q     <= ex_d;
    ey_q     <= ey_d;
    eqv_q    <= eqv_d;
    boxx_q   <= boxx_d;
    spany_q  <= spany_d;
    dynz_q   <= (dy_d != '0);
    dyneg_q  <= dy_d[DW-1];
    p1_q     <= dy_q * ex_q;
    p2_q     <= dx_q * ey_q;
    eqv2_q   <= eqv_q;
    boxx2_q  <= boxx_q;
    spany2_q <= spany_q;
    dynz2_q  <= dynz_q;
    dyneg2_q <= dyneg_q;
  end

  // The ray meets the edge at or right of the point when the cross product
  // has no sign opposite to the one that dy calls for.
  always_comb begin
    c_diff  = (PW+1)'(p1_q) - (PW+1)'(p2_q);
    c_zero  = (c_diff == '0);
    c_neg   = c_diff[PW];
    hit_onb = eqv2_q || (boxx2_q && spany2_q && c_zero);
    hit_cnt = dynz2_q && spany2_q && (dyneg2_q ? !c_neg : (c_neg || c_zero));
    cnt_d   = cnt_q;
    onb_d   = onb_q;
    if (clr_i) begin
      cnt_d = '0;
      onb_d = 1'b0;
    end else if (s2_v_q) begin
      cnt_d = cnt_q + CntW'(hit_cnt);
      onb_d = onb_q || hit_onb;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      cnt_q  <= '0;
      onb_q  <= 1'b0;
    end else begin
      s1_v_q <= feed_i;
      s2_v_q <= s1_v_q;
      cnt_q  <= cnt_d;
      onb_q  <= onb_d;
    end
  end

  assign stat_o.busy   = s1_v_q || s2_v_q;
  assign stat_o.on_bnd = onb_q;
  assign cnt_o         = cnt_q;

endmodule

@@ rtl/point_in_polygon_test_top.sv @@
`timescale 1ns / 1ps
// Top level of the point-in-polygon test: vertex store, walk sequencer and result
// register. Depends on pip_pkg, pip_item_if, pip_ram and pip_edge_unit.

// Clear and append items are taken in the idle state, which they do not leave. A
// query walks the stored vertices before the block is ready again (an empty
// polygon skips the walk): the vertex RAM's single read port supplies one vertex per
// cycle, and each edge passes through the three-stage edge unit, which must
// drain before the result is registered. The result waits in an output register,
// so the next item can be accepted while it is still pending.

module point_in_polygon_test_top #(
  parameter int unsigned MaxVertices = pip_pkg::MaxVerticesDef,
  parameter int unsigned CoordBits   = pip_pkg::CoordBitsDef
) (
  input logic      clk_i,
  input logic      rst_ni,
  pip_item_if.sink item_i,
  pip_res_if.source res_o
);
  import pip_pkg::*;

  localparam int unsigned AW   = $clog2(MaxVertices);
  localparam int unsigned CntW = $clog2(MaxVertices + 1);
  localparam int unsigned VW   = 2 * CoordBits;

  pip_state_e                  state_q, state_d;
  logic [CntW-1:0]             count_q, count_d;
  logic                        ovf_q, ovf_d;
  logic [AW-1:0]               rd_idx_q, rd_idx_d, last_idx;
  logic                        arr_v_q, arr_first_q;
  logic signed [CoordBits-1:0] px_q, py_q;
  logic [VW-1:0]               first_q, prev_q, rdata, v2;
  logic                        item_fire, full, ram_we, feed, clr_acc;
  logic                        item_ready, walk_rd, tail_feed, load_res, out_free;
  pip_mode_e                   mode;
  pip_stat_t                   stat;
  logic [CntW-1:0]             cnt;
  logic                        res_valid_q, res_inside_q, res_onb_q, res_ovf_q;
  logic [CrossBits-1:0]        res_cross_q;

  assign item_fire = item_i.valid && item_ready;
  assign mode      = pip_mode_e'(item_i.mode);
  assign full      = (count_q >= CntW'(MaxVertices));
  assign last_idx  = AW'(count_q - CntW'(1));
  assign out_free  = !res_valid_q || res_o.ready;
  assign ram_we    = item_fire && (mode == ModeAppend) && !full;
  assign clr_acc   = item_fire && (mode == ModeQuery);

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (item_fire && (mode == ModeQuery)) begin
          state_d = (count_q != '0) ? StWalk : StDrain;
        end
      end
      StWalk: begin
        if (rd_idx_q == last_idx) begin
          state_d = StWrap;
        end
      end
      StWrap:  state_d = StTail;
      StTail:  state_d = StDrain;
      StDrain: begin
        if (load_res) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    item_ready = 1'b0;
    walk_rd    = 1'b0;
    tail_feed  = 1'b0;
    load_res   = 1'b0;
    case (state_q)
      StIdle:  item_ready = 1'b1;
      StWalk:  walk_rd = 1'b1;
      StWrap:  ;
      StTail:  tail_feed = 1'b1;
      StDrain: load_res = !stat.busy && out_free;
      default: ;
    endcase
  end

  always_comb begin
    count_d = count_q;
    ovf_d   = ovf_q;
    if (item_fire) begin
      case (mode)
        ModeClear: begin
          count_d = '0;
          ovf_d   = 1'b0;
        end
        ModeAppend: begin
          if (full) begin
            ovf_d = 1'b1;
          end else begin
            count_d = count_q + CntW'(1);
          end
        end
        default: ;
      endcase
    end
    rd_idx_d = walk_rd ? rd_idx_q + AW'(1) : '0;
  end

  pip_ram #(
    .Width (VW),
    .Depth (MaxVertices)
  ) u_vtx_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (AW'(count_q)),
    .wdata_i ({item_i.point_y, item_i.point_x}),
    .raddr_i (rd_idx_q),
    .rdata_o (rdata)
  );

  // Each arriving vertex closes the edge from the one before; the tail cycle
  // closes the polygon from the last vertex back to the first.
  assign feed = (arr_v_q && !arr_first_q) || tail_feed;
  assign v2   = tail_feed ? first_q : rdata;

  pip_edge_unit #(
    .MaxVertices (MaxVertices),
    .CoordBits   (CoordBits)
  ) u_edge (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .clr_i  (clr_acc),
    .feed_i (feed),
    .x1_i   (prev_q[CoordBits-1:0]),
    .y1_i   (prev_q[VW-1:CoordBits]),
    .x2_i   (v2[CoordBits-1:0]),
    .y2_i   (v2[VW-1:CoordBits]),
    .px_i   (px_q),
    .py_i   (py_q),
    .stat_o (stat),
    .cnt_o  (cnt)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      count_q     <= '0;
      ovf_q       <= 1'b0;
      rd_idx_q    <= '0;
      arr_v_q     <= 1'b0;
      arr_first_q <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      ovf_q       <= ovf_d;
      rd_idx_q    <= rd_idx_d;
      arr_v_q     <= walk_rd;
      arr_first_q <= walk_rd && (rd_idx_q == '0);
      if (load_res) begin
        res_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (clr_acc) begin
      px_q <= item_i.point_x;
      py_q <= item_i.point_y;
    end
    if (arr_v_q) begin
      prev_q <= rdata;
      if (arr_first_q) begin
        first_q <= rdata;
      end
    end
    if (load_res) begin
      res_inside_q <= cnt[0];
      res_onb_q    <= stat.on_bnd;
      res_cross_q  <= CrossBits'(cnt);
      res_ovf_q    <= ovf_q;
    end
  end

  assign item_i.ready      = item_ready;
  assign res_o.valid       = res_valid_q;
  assign res_o.inside_res  = res_inside_q;
  assign res_o.on_boundary = res_onb_q;
  assign res_o.crossings   = res_cross_q;
  assign res_o.overflowed  = res_ovf_q;

endmodule
